// ===== sv/vigenere_cipher_stream_assert.svh =====
// Assertion macros shared by the cipher stream RTL.
// All checks run on aclk and are muted while aresetn is low.
`ifndef VIGENERE_CIPHER_STREAM_ASSERT_SVH
`define VIGENERE_CIPHER_STREAM_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define VCS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define VCS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/vcs_pkg.sv =====
package vcs_pkg;

    localparam int BYTE_W    = 8;
    localparam int KEY_MAX   = 16;
    localparam int KEY_POS_W = $clog2(KEY_MAX);
    localparam int KEY_LEN_W = KEY_POS_W + 1;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 2;
    localparam int SHIFT_W   = 5;
    localparam int SUM_W     = SHIFT_W + 1;

    localparam logic [BYTE_W-1:0] CHAR_A    = 8'h61;
    localparam logic [BYTE_W-1:0] CHAR_Z    = 8'h7A;
    localparam logic [SUM_W-1:0]  ALPHA_LEN = 6'd26;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEY_LOW  = 2'd0,
        REG_KEY_HIGH = 2'd1,
        REG_KEY_LEN  = 2'd2,
        REG_DECRYPT  = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [CFG_W-1:0]     key_high;
        logic [CFG_W-1:0]     key_low;
        logic [KEY_LEN_W-1:0] key_len;
        logic                 decrypt;
    } vcs_cfg_t;

    typedef struct packed {
        logic [KEY_POS_W-1:0] key_pos;
        logic                 last;
        logic [BYTE_W-1:0]    data;
    } vcs_item_t;

    typedef struct packed {
        logic              last;
        logic [BYTE_W-1:0] data;
    } vcs_result_t;

    function automatic logic is_lower(input logic [BYTE_W-1:0] c);
        return (c >= CHAR_A) && (c <= CHAR_Z);
    endfunction

endpackage

// ===== sv/vigenere_cipher_stream.sv =====
// Channel   Direction  tdata (low bit up)   tlast         Notes
// s_        in         [7:0] in_byte        in_last       one character a request
// m_        out        [7:0] out_byte       out_last      one result per request
// cfg_      in         [63:0] register      -             index 0..3, no read-back
//
// One request per cycle sustained while m_tready is high. The input register takes a
// request; its result is valid once loaded into the result register. Throughput is
// set by these two registers, with the key byte select, one add and one compare and
// subtract of 26 between them; the key-slot counter sits in front of the input register.
// Reset clears both stage valids, the key slot and the configuration registers
// (key length 1).
// With m_tready low the result holds and the input register takes one more
// request, then s_tready drops until the result is taken.
module vigenere_cipher_stream (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [vcs_pkg::BYTE_W-1:0]    s_tdata,   // [7:0] in_byte
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [vcs_pkg::BYTE_W-1:0]    m_tdata,   // [7:0] out_byte
    output logic                          m_tlast,
    input  logic                          cfg_wr_en,
    input  logic [vcs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [vcs_pkg::CFG_W-1:0]     cfg_wr_data
);
    import vcs_pkg::*;

`include "vigenere_cipher_stream_assert.svh"

    vcs_cfg_t             cfg;
    vcs_item_t            item;
    vcs_result_t          result;
    logic                 item_valid;
    logic                 out_ready;
    logic [KEY_POS_W-1:0] key_pos;

    vcs_cfg_regs u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    vcs_ingress u_ingress (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .key_len    (cfg.key_len),
        .down_ready (out_ready),
        .item_valid (item_valid),
        .item       (item),
        .key_pos    (key_pos)
    );

    vcs_cipher u_cipher (
        .item   (item),
        .cfg    (cfg),
        .result (result)
    );

    vcs_egress u_egress (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (item_valid),
        .res       (result),
        .up_ready  (out_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // Key slot restarts after the last byte of a line
    `VCS_ASSERT_NEXT(a_pos_restart, s_tvalid && s_tready && s_tlast, key_pos == '0,
        "key slot not cleared after line end")

    // Input only backs up when both stages hold a request
    `VCS_ASSERT_SAME(a_full_stall, !s_tready, item_valid && m_tvalid,
        "input stalled with a free stage")

    // Letters stay letters and other bytes stay non-letters
    `VCS_ASSERT_SAME(a_letter_class, item_valid,
        is_lower(item.data) == is_lower(result.data), "letter class changed")

endmodule

// ===== sv/vcs_cfg_regs.sv =====
module vcs_cfg_regs (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [vcs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [vcs_pkg::CFG_W-1:0]   cfg_wr_data,
    output vcs_pkg::vcs_cfg_t           cfg
);
    import vcs_pkg::*;

    logic [CFG_W-1:0]     key_low_reg,  key_low_next;
    logic [CFG_W-1:0]     key_high_reg, key_high_next;
    logic [KEY_LEN_W-1:0] key_len_reg,  key_len_next;
    logic                 decrypt_reg,  decrypt_next;
    logic [KEY_LEN_W-1:0] len_raw;
    logic [KEY_LEN_W-1:0] len_sat;

    // Clamp the written length to 1..KEY_MAX
    always_comb begin
        len_raw = cfg_wr_data[KEY_LEN_W-1:0];
        if (len_raw == '0) begin
            len_sat = KEY_LEN_W'(1);
        end else if (len_raw > KEY_LEN_W'(KEY_MAX)) begin
            len_sat = KEY_LEN_W'(KEY_MAX);
        end else begin
            len_sat = len_raw;
        end
    end

    // Decode the register write
    always_comb begin
        key_low_next  = key_low_reg;
        key_high_next = key_high_reg;
        key_len_next  = key_len_reg;
        decrypt_next  = decrypt_reg;
        if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_index))
                REG_KEY_LOW:  key_low_next  = cfg_wr_data;
                REG_KEY_HIGH: key_high_next = cfg_wr_data;
                REG_KEY_LEN:  key_len_next  = len_sat;
                REG_DECRYPT:  decrypt_next  = cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
            key_len_reg  <= KEY_LEN_W'(1);
            decrypt_reg  <= 1'b0;
        end else begin
            key_low_reg  <= key_low_next;
            key_high_reg <= key_high_next;
            key_len_reg  <= key_len_next;
            decrypt_reg  <= decrypt_next;
        end
    end

    assign cfg.key_low  = key_low_reg;
    assign cfg.key_high = key_high_reg;
    assign cfg.key_len  = key_len_reg;
    assign cfg.decrypt  = decrypt_reg;

endmodule

// ===== sv/vcs_ingress.sv =====
module vcs_ingress (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [vcs_pkg::BYTE_W-1:0]     s_tdata,
    input  logic                           s_tlast,
    input  logic [vcs_pkg::KEY_LEN_W-1:0]  key_len,
    input  logic                           down_ready,
    output logic                           item_valid,
    output vcs_pkg::vcs_item_t             item,
    output logic [vcs_pkg::KEY_POS_W-1:0]  key_pos
);
    import vcs_pkg::*;

    logic                 valid_reg, valid_next;
    vcs_item_t            item_reg,  item_next;
    logic [KEY_POS_W-1:0] key_pos_reg, key_pos_next;
    logic [KEY_POS_W-1:0] pos_eff;
    logic [KEY_LEN_W-1:0] pos_inc;
    logic                 accept;

    assign s_tready = !valid_reg || down_ready;
    assign accept   = s_tvalid && s_tready;

    // Pick the key slot for this request; drop a slot beyond a shortened key
    always_comb begin
        if ({1'b0, key_pos_reg} >= key_len) begin
            pos_eff = '0;
        end else begin
            pos_eff = key_pos_reg;
        end
        pos_inc = {1'b0, pos_eff} + KEY_LEN_W'(1);
    end

    // Advance the key slot, wrap at key length, restart after the line end
    always_comb begin
        key_pos_next = key_pos_reg;
        valid_next   = valid_reg;
        item_next    = item_reg;
        if (accept) begin
            if (s_tlast || (pos_inc >= key_len)) begin
                key_pos_next = '0;
            end else begin
                key_pos_next = pos_inc[KEY_POS_W-1:0];
            end
            valid_next        = 1'b1;
            item_next.key_pos = pos_eff;
            item_next.last    = s_tlast;
            item_next.data    = s_tdata;
        end else if (down_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= 1'b0;
            key_pos_reg <= '0;
        end else begin
            valid_reg   <= valid_next;
            key_pos_reg <= key_pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;
    assign key_pos    = key_pos_reg;

endmodule

// ===== sv/vcs_cipher.sv =====
module vcs_cipher (
    input  vcs_pkg::vcs_item_t   item,
    input  vcs_pkg::vcs_cfg_t    cfg,
    output vcs_pkg::vcs_result_t result
);
    import vcs_pkg::*;

    logic [2*CFG_W-1:0]  key_all;
    logic [BYTE_W-1:0]   key_byte;
    logic [BYTE_W-1:0]   key_off;
    logic [BYTE_W-1:0]   chr_off;
    logic [SHIFT_W-1:0]  shift;
    logic [SHIFT_W-1:0]  idx;
    logic [SUM_W-1:0]    sum;
    logic [SUM_W-1:0]    wrapped;

    assign key_all  = {cfg.key_high, cfg.key_low};
    assign key_byte = key_all[{item.key_pos, 3'b000} +: BYTE_W];

    // Shift is the key letter's alphabet index plus one, zero for other bytes
    always_comb begin
        key_off = key_byte - CHAR_A + BYTE_W'(1);
        if (is_lower(key_byte)) begin
            shift = key_off[SHIFT_W-1:0];
        end else begin
            shift = '0;
        end
    end

    // Rotate the letter by the shift, one subtract of 26 keeps it in range
    always_comb begin
        chr_off = item.data - CHAR_A;
        idx     = chr_off[SHIFT_W-1:0];
        if (cfg.decrypt) begin
            sum = {1'b0, idx} + ALPHA_LEN - {1'b0, shift};
        end else begin
            sum = {1'b0, idx} + {1'b0, shift};
        end
        if (sum >= ALPHA_LEN) begin
            wrapped = sum - ALPHA_LEN;
        end else begin
            wrapped = sum;
        end
    end

    // Pass non-letters through untouched
    always_comb begin
        result.last = item.last;
        if (is_lower(item.data)) begin
            result.data = CHAR_A + {{(BYTE_W-SHIFT_W){1'b0}}, wrapped[SHIFT_W-1:0]};
        end else begin
            result.data = item.data;
        end
    end

endmodule

// ===== sv/vcs_egress.sv =====
module vcs_egress (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       res_valid,
    input  vcs_pkg::vcs_result_t       res,
    output logic                       up_ready,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [vcs_pkg::BYTE_W-1:0] m_tdata,
    output logic                       m_tlast
);
    import vcs_pkg::*;

    logic        valid_reg, valid_next;
    vcs_result_t res_reg,   res_next;

    assign up_ready = !valid_reg || m_tready;

    // Load a new result when the register is free or being drained
    always_comb begin
        valid_next = valid_reg;
        res_next   = res_reg;
        if (up_ready) begin
            valid_next = res_valid;
            res_next   = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = res_reg.data;
    assign m_tlast  = res_reg.last;

endmodule
